// File: sv/dertlv_pkg.sv
// ----------------------------------------------------------------------------
// dertlv_pkg
// Shared types and codes for the DER TLV header parser: parse phases,
// result status codes, expected kinds and the universal tag values.
// ----------------------------------------------------------------------------
package dertlv_pkg;

    // parse phase of the object in progress
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LEN1,
        PH_LENX,
        PH_BODY
    } phase_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BUF_SHORT   = 3'd1,
        ST_BAD_LEN     = 3'd2,
        ST_OVERRUN     = 3'd3,
        ST_WRONG_TAG   = 3'd4,
        ST_EMPTY_BITS  = 3'd5,
        ST_UNUSED_BITS = 3'd6
    } status_t;

    // expected kinds carried on the first beat
    localparam logic [2:0] KIND_ANY     = 3'd0;
    localparam logic [2:0] KIND_INTEGER = 3'd1;
    localparam logic [2:0] KIND_SEQ     = 3'd2;
    localparam logic [2:0] KIND_OCTETS  = 3'd3;
    localparam logic [2:0] KIND_OID     = 3'd4;
    localparam logic [2:0] KIND_BITSTR  = 3'd5;
    localparam logic [2:0] KIND_UTF8    = 3'd6;

    // universal tag bytes
    localparam logic [7:0] TAG_INTEGER = 8'h02;
    localparam logic [7:0] TAG_SEQ     = 8'h30;
    localparam logic [7:0] TAG_OCTETS  = 8'h04;
    localparam logic [7:0] TAG_OID     = 8'h06;
    localparam logic [7:0] TAG_BITSTR  = 8'h03;
    localparam logic [7:0] TAG_UTF8    = 8'h0C;

    // largest legal unused-bits count in a bit string
    localparam logic [7:0] MAX_UNUSED_BITS = 8'd7;

    // payload widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 3;

endpackage

// File: sv/der_tlv_header_parser.sv
// ----------------------------------------------------------------------------
// der_tlv_header_parser
// Byte-stream parser for the header of one ASN.1 DER object: tag, short or
// long length, bounds and tag checks, sign-zero drop for integers and
// unused-bits check for bit strings. One result per object.
//
//  channel | direction | tdata (low bit up)                        | tuser
//  --------+-----------+-------------------------------------------+----------------
//  s_      | in        | data_byte[7:0], avail[39:8]               | command[2:0], first[3]
//  m_      | out       | tag[7:0], value_offset[10:8],             | status[2:0]
//          |           | value_length[42:11], consumed[74:43]      |
//
// One byte is taken per cycle, back to back. A result appears on m_ after the
// byte that decides it has passed the input register and then the result
// register. Every byte passes the single decode stage between those two
// registers. While a result waits on m_, bytes that give no result still
// pass; a byte that gives one is held in the input register with s_tready
// low until the waiting result is taken.
// rst_n clears the phase and all held header state at once.
// ----------------------------------------------------------------------------
module der_tlv_header_parser #(
    parameter int MAX_LEN_OCTETS = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // data_byte[7:0], avail[39:8]
    input  logic [dertlv_pkg::S_TDATA_W-1:0] s_tdata,
    // command[2:0], first[3]
    input  logic [dertlv_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tag[7:0], value_offset[10:8], value_length[42:11], consumed[74:43], zero pad
    output logic [dertlv_pkg::M_TDATA_W-1:0] m_tdata,
    // status[2:0]
    output logic [dertlv_pkg::M_TUSER_W-1:0] m_tuser
);

    localparam int OL_BITS = $clog2(MAX_LEN_OCTETS + 1);
    localparam int OL_W    = (OL_BITS > 2) ? OL_BITS : 2;
    localparam int HC_W    = $clog2(MAX_LEN_OCTETS + 3);

    // input register
    logic        in_valid_reg;
    logic [2:0]  in_cmd_reg;
    logic        in_first_reg;
    logic [7:0]  in_byte_reg;
    logic [31:0] in_avail_reg;

    // parse state
    dertlv_pkg::phase_t phase_reg, phase_next;
    logic [2:0]         kind_reg, kind_next;
    logic [7:0]         tag_reg, tag_next;
    logic [31:0]        avail_reg, avail_next;
    logic [31:0]        acc_reg, acc_next;
    logic [OL_W-1:0]    ol_reg, ol_next;
    logic [HC_W-1:0]    hc_reg, hc_next;
    logic [7:0]         fc_reg, fc_next;
    logic               big_reg, big_next;

    // result register
    logic                m_valid_reg;
    dertlv_pkg::status_t res_status_reg;
    logic [7:0]          res_tag_reg;
    logic [2:0]          res_off_reg;
    logic [31:0]         res_len_reg;
    logic [31:0]         res_cons_reg;

    // decode stage outputs
    logic                emit;
    dertlv_pkg::status_t emit_status;
    logic [2:0]          emit_off;
    logic [31:0]         emit_len;
    logic [31:0]         emit_cons;
    logic                proc_go;
    logic                in_load;

    // header-done helpers
    logic            hd_check;
    logic [HC_W-1:0] hd_hc;
    logic [31:0]     hd_acc;
    logic            hd_big;
    logic [32:0]     hd_total;
    logic            tag_ok;
    logic [HC_W:0]   hc_ext;
    logic [HC_W:0]   hc_p1;
    logic [31:0]     body_cons;
    logic [OL_W-1:0] ol_dec;

    // handshake between the stages
    assign proc_go  = in_valid_reg && (!emit || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc_go;
    assign in_load  = s_tvalid && s_tready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_load)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc_go)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_byte_reg  <= s_tdata[7:0];
            in_avail_reg <= s_tdata[39:8];
            in_cmd_reg   <= s_tuser[2:0];
            in_first_reg <= s_tuser[3];
        end
    end

    // tag check against the expected kind
    always_comb
    begin
        unique case (kind_reg)
            dertlv_pkg::KIND_INTEGER: tag_ok = (tag_reg == dertlv_pkg::TAG_INTEGER);
            dertlv_pkg::KIND_SEQ:     tag_ok = (tag_reg == dertlv_pkg::TAG_SEQ);
            dertlv_pkg::KIND_OCTETS:  tag_ok = (tag_reg == dertlv_pkg::TAG_OCTETS);
            dertlv_pkg::KIND_OID:     tag_ok = (tag_reg == dertlv_pkg::TAG_OID);
            dertlv_pkg::KIND_BITSTR:  tag_ok = (tag_reg == dertlv_pkg::TAG_BITSTR);
            dertlv_pkg::KIND_UTF8:    tag_ok = (tag_reg == dertlv_pkg::TAG_UTF8);
            default:                  tag_ok = 1'b1;
        endcase
    end

    // decode stage: next state and result for the byte in the input register
    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        tag_next    = tag_reg;
        avail_next  = avail_reg;
        acc_next    = acc_reg;
        ol_next     = ol_reg;
        hc_next     = hc_reg;
        fc_next     = fc_reg;
        big_next    = big_reg;
        emit        = 1'b0;
        emit_status = dertlv_pkg::ST_OK;
        emit_off    = 3'd0;
        emit_len    = 32'd0;
        emit_cons   = 32'd0;
        hd_check    = 1'b0;
        hd_hc       = hc_reg;
        hd_acc      = acc_reg;
        hd_big      = big_reg;
        ol_dec      = ol_reg - OL_W'(1);
        hc_ext      = {1'b0, hc_reg};
        hc_p1       = hc_ext + (HC_W + 1)'(1);
        body_cons   = acc_reg + 32'(hc_reg);

        if (in_first_reg)
        begin
            // tag byte: restart the object
            kind_next  = in_cmd_reg;
            tag_next   = in_byte_reg;
            avail_next = in_avail_reg;
            hc_next    = HC_W'(1);
            acc_next   = 32'd0;
            ol_next    = '0;
            fc_next    = 8'd0;
            big_next   = 1'b0;
            if (in_avail_reg < 32'd2)
            begin
                emit        = 1'b1;
                emit_status = dertlv_pkg::ST_BUF_SHORT;
                phase_next  = dertlv_pkg::PH_IDLE;
            end
            else
            begin
                phase_next = dertlv_pkg::PH_LEN1;
            end
        end
        else
        begin
            unique case (phase_reg)
                dertlv_pkg::PH_LEN1:
                begin
                    // first length octet: short form or count of long-form octets
                    hc_next = HC_W'(2);
                    hd_hc   = HC_W'(2);
                    if (!in_byte_reg[7])
                    begin
                        acc_next = {24'd0, in_byte_reg};
                        hd_acc   = {24'd0, in_byte_reg};
                        hd_check = 1'b1;
                    end
                    else if (in_byte_reg[6:0] == 7'd0 ||
                             in_byte_reg[6:0] > 7'(MAX_LEN_OCTETS))
                    begin
                        ol_next     = OL_W'(in_byte_reg[6:0]);
                        emit        = 1'b1;
                        emit_status = dertlv_pkg::ST_BAD_LEN;
                        phase_next  = dertlv_pkg::PH_IDLE;
                    end
                    else
                    begin
                        ol_next    = OL_W'(in_byte_reg[6:0]);
                        phase_next = dertlv_pkg::PH_LENX;
                    end
                end
                dertlv_pkg::PH_LENX:
                begin
                    // long-form length octet
                    hd_big   = big_reg || (acc_reg[31:24] != 8'd0);
                    hd_acc   = {acc_reg[23:0], in_byte_reg};
                    hd_hc    = hc_reg + HC_W'(1);
                    big_next = hd_big;
                    acc_next = hd_acc;
                    hc_next  = hd_hc;
                    ol_next  = ol_dec;
                    hd_check = (ol_dec == '0);
                end
                dertlv_pkg::PH_BODY:
                begin
                    // first content bytes of integers and bit strings
                    if (kind_reg == dertlv_pkg::KIND_INTEGER)
                    begin
                        if (ol_reg == OL_W'(2))
                        begin
                            fc_next = in_byte_reg;
                            ol_next = OL_W'(1);
                        end
                        else
                        begin
                            emit        = 1'b1;
                            emit_status = dertlv_pkg::ST_OK;
                            emit_cons   = body_cons;
                            phase_next  = dertlv_pkg::PH_IDLE;
                            if (fc_reg == 8'h00 && in_byte_reg[7])
                            begin
                                emit_off = hc_p1[2:0];
                                emit_len = acc_reg - 32'd1;
                            end
                            else
                            begin
                                emit_off = hc_ext[2:0];
                                emit_len = acc_reg;
                            end
                        end
                    end
                    else
                    begin
                        emit       = 1'b1;
                        emit_cons  = body_cons;
                        phase_next = dertlv_pkg::PH_IDLE;
                        if (in_byte_reg > dertlv_pkg::MAX_UNUSED_BITS)
                        begin
                            emit_status = dertlv_pkg::ST_UNUSED_BITS;
                        end
                        else
                        begin
                            emit_status = dertlv_pkg::ST_OK;
                            emit_off    = hc_p1[2:0];
                            emit_len    = acc_reg - 32'd1;
                        end
                    end
                end
                default:
                begin
                    // idle: stray bytes are dropped
                end
            endcase
        end

        // header complete: bounds, tag and kind-specific follow-up
        hd_total = {1'b0, hd_acc} + 33'(hd_hc);
        if (hd_check)
        begin
            if (hd_big || hd_total > {1'b0, avail_reg})
            begin
                emit        = 1'b1;
                emit_status = dertlv_pkg::ST_OVERRUN;
                phase_next  = dertlv_pkg::PH_IDLE;
            end
            else if (!tag_ok)
            begin
                emit        = 1'b1;
                emit_status = dertlv_pkg::ST_WRONG_TAG;
                emit_cons   = hd_total[31:0];
                phase_next  = dertlv_pkg::PH_IDLE;
            end
            else if (kind_reg == dertlv_pkg::KIND_INTEGER && hd_acc > 32'd1)
            begin
                ol_next    = OL_W'(2);
                phase_next = dertlv_pkg::PH_BODY;
            end
            else if (kind_reg == dertlv_pkg::KIND_BITSTR)
            begin
                if (hd_acc == 32'd0)
                begin
                    emit        = 1'b1;
                    emit_status = dertlv_pkg::ST_EMPTY_BITS;
                    emit_cons   = hd_total[31:0];
                    phase_next  = dertlv_pkg::PH_IDLE;
                end
                else
                begin
                    ol_next    = OL_W'(1);
                    phase_next = dertlv_pkg::PH_BODY;
                end
            end
            else
            begin
                emit        = 1'b1;
                emit_status = dertlv_pkg::ST_OK;
                emit_off    = hd_total[2:0] - hd_acc[2:0];
                emit_len    = hd_acc;
                emit_cons   = hd_total[31:0];
                phase_next  = dertlv_pkg::PH_IDLE;
            end
        end
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dertlv_pkg::PH_IDLE;
            kind_reg  <= 3'd0;
            tag_reg   <= 8'd0;
            avail_reg <= 32'd0;
            acc_reg   <= 32'd0;
            ol_reg    <= '0;
            hc_reg    <= '0;
            fc_reg    <= 8'd0;
            big_reg   <= 1'b0;
        end
        else if (proc_go)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            tag_reg   <= tag_next;
            avail_reg <= avail_next;
            acc_reg   <= acc_next;
            ol_reg    <= ol_next;
            hc_reg    <= hc_next;
            fc_reg    <= fc_next;
            big_reg   <= big_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (proc_go && emit)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_go && emit)
        begin
            res_status_reg <= emit_status;
            res_tag_reg    <= tag_next;
            res_off_reg    <= emit_off;
            res_len_reg    <= emit_len;
            res_cons_reg   <= emit_cons;
        end
    end

    // output packing
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_status_reg;
    assign m_tdata  = {5'd0, res_cons_reg, res_len_reg, res_off_reg, res_tag_reg};

endmodule

// File: tb/der_tlv_header_parser_tb.sv
// ----------------------------------------------------------------------------
// der_tlv_header_parser_tb
// Self-checking bench for the DER TLV header parser. A queue of byte beats
// (a short directed set, then random objects, noise and broken headers) is
// played into the slave side. Each accepted beat goes through a local
// behavioural parser that queues the expected result. The master side is
// checked field by field against that queue. Both sides idle at random, and
// the receiver also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module der_tlv_header_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_LEN_OCTETS = 4;
    localparam logic [2:0]  KIND_UNLISTED  = 3'd7;
    localparam int          N_ITEMS        = 1000;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          HOLD_AFTER     = 300;
    localparam int          STALL_LIMIT    = 4000;
    localparam int          DRAIN_CYCLES   = 10;

    // one input beat
    typedef struct packed {
        logic [2:0]  command;
        logic        first;
        logic [7:0]  data_byte;
        logic [31:0] avail;
    } tlv_beat_t;

    // one parse result
    typedef struct {
        dertlv_pkg::status_t status;
        logic [7:0]          tag;
        logic [2:0]          value_offset;
        logic [31:0]         value_length;
        logic [31:0]         consumed;
    } tlv_result_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [dertlv_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [dertlv_pkg::S_TUSER_W-1:0] s_tuser = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [dertlv_pkg::M_TDATA_W-1:0] m_tdata;
    logic [dertlv_pkg::M_TUSER_W-1:0] m_tuser;

    tlv_beat_t   beat_queue[$];
    tlv_result_t expected_results[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          error_count = 0;
    int          in_beats = 0;
    int          stall_cycles = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;
    logic        beat_taken = 1'b0;

    // parser state mirror
    dertlv_pkg::phase_t p_phase = dertlv_pkg::PH_IDLE;
    logic [2:0]         p_kind = '0;
    logic [7:0]         p_tag = '0;
    logic [31:0]        p_avail = '0;
    logic [31:0]        p_len_acc = '0;
    logic [6:0]         p_left = '0;
    logic [2:0]         p_hdr_count = '0;
    logic [7:0]         p_first_content = '0;
    logic               p_too_big = 1'b0;

    der_tlv_header_parser #(
        .MAX_LEN_OCTETS (MAX_LEN_OCTETS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    // universal tag for a kind, zero where any tag goes
    function automatic logic [7:0] kind_tag(logic [2:0] kind);
        case (kind)
            dertlv_pkg::KIND_INTEGER: return dertlv_pkg::TAG_INTEGER;
            dertlv_pkg::KIND_SEQ:     return dertlv_pkg::TAG_SEQ;
            dertlv_pkg::KIND_OCTETS:  return dertlv_pkg::TAG_OCTETS;
            dertlv_pkg::KIND_OID:     return dertlv_pkg::TAG_OID;
            dertlv_pkg::KIND_BITSTR:  return dertlv_pkg::TAG_BITSTR;
            dertlv_pkg::KIND_UTF8:    return dertlv_pkg::TAG_UTF8;
            default:                  return 8'h00;
        endcase
    endfunction

    // queue a result and return to idle
    function automatic void post_result(dertlv_pkg::status_t st, logic [2:0] off,
                                        logic [31:0] len, logic [31:0] cons);
        tlv_result_t r;
        r.status       = st;
        r.tag          = p_tag;
        r.value_offset = off;
        r.value_length = len;
        r.consumed     = cons;
        expected_results.push_back(r);
        p_phase = dertlv_pkg::PH_IDLE;
    endfunction

    // bounds and tag checks once the whole header is in
    function automatic void close_header();
        logic [32:0] total;
        logic        tag_ok;
        total  = {1'b0, p_len_acc} + 33'(p_hdr_count);
        tag_ok = (p_kind == dertlv_pkg::KIND_ANY) || (p_kind == KIND_UNLISTED) ||
                 (p_tag == kind_tag(p_kind));
        if (p_too_big || total > {1'b0, p_avail})
            post_result(dertlv_pkg::ST_OVERRUN, '0, '0, '0);
        else if (!tag_ok)
            post_result(dertlv_pkg::ST_WRONG_TAG, '0, '0, total[31:0]);
        else if (p_kind == dertlv_pkg::KIND_INTEGER && p_len_acc > 1)
        begin
            p_left  = 7'd2;
            p_phase = dertlv_pkg::PH_BODY;
        end
        else if (p_kind == dertlv_pkg::KIND_BITSTR)
        begin
            if (p_len_acc == 0)
                post_result(dertlv_pkg::ST_EMPTY_BITS, '0, '0, total[31:0]);
            else
            begin
                p_left  = 7'd1;
                p_phase = dertlv_pkg::PH_BODY;
            end
        end
        else
            post_result(dertlv_pkg::ST_OK, p_hdr_count, p_len_acc, total[31:0]);
    endfunction

    // advance the parser mirror by one accepted beat
    function automatic void parse_beat(tlv_beat_t bt);
        logic [31:0] cons;
        logic [7:0]  b;
        b = bt.data_byte;
        if (bt.first)
        begin
            p_kind          = bt.command;
            p_tag           = b;
            p_avail         = bt.avail;
            p_hdr_count     = 3'd1;
            p_len_acc       = '0;
            p_left          = '0;
            p_first_content = '0;
            p_too_big       = 1'b0;
            if (bt.avail < 2)
                post_result(dertlv_pkg::ST_BUF_SHORT, '0, '0, '0);
            else
                p_phase = dertlv_pkg::PH_LEN1;
        end
        else
        begin
            case (p_phase)
                dertlv_pkg::PH_LEN1:
                begin
                    p_hdr_count = 3'd2;
                    if (b < 8'h80)
                    begin
                        p_len_acc = {24'd0, b};
                        close_header();
                    end
                    else
                    begin
                        p_left = b[6:0];
                        if (p_left == 0 || p_left > MAX_LEN_OCTETS)
                            post_result(dertlv_pkg::ST_BAD_LEN, '0, '0, '0);
                        else
                            p_phase = dertlv_pkg::PH_LENX;
                    end
                end
                dertlv_pkg::PH_LENX:
                begin
                    if (p_len_acc[31:24] != 0)
                        p_too_big = 1'b1;
                    p_len_acc   = {p_len_acc[23:0], b};
                    p_hdr_count = p_hdr_count + 3'd1;
                    p_left      = p_left - 7'd1;
                    if (p_left == 0)
                        close_header();
                end
                dertlv_pkg::PH_BODY:
                begin
                    cons = 32'(p_hdr_count) + p_len_acc;
                    if (p_kind == dertlv_pkg::KIND_INTEGER)
                    begin
                        // sign zero goes only when the next byte has its top bit set
                        if (p_left == 2)
                        begin
                            p_first_content = b;
                            p_left          = 7'd1;
                        end
                        else if (p_first_content == 8'h00 && b[7])
                            post_result(dertlv_pkg::ST_OK, p_hdr_count + 3'd1,
                                        p_len_acc - 32'd1, cons);
                        else
                            post_result(dertlv_pkg::ST_OK, p_hdr_count, p_len_acc, cons);
                    end
                    else if (b > dertlv_pkg::MAX_UNUSED_BITS)
                        post_result(dertlv_pkg::ST_UNUSED_BITS, '0, '0, cons);
                    else
                        post_result(dertlv_pkg::ST_OK, p_hdr_count + 3'd1,
                                    p_len_acc - 32'd1, cons);
                end
                default: ;
            endcase
        end
    endfunction

    task automatic push_beat(logic [2:0] cmd, logic first, logic [7:0] b, logic [31:0] av);
        tlv_beat_t t;
        t.command   = cmd;
        t.first     = first;
        t.data_byte = b;
        t.avail     = av;
        beat_queue.push_back(t);
    endtask

    // continuation byte, with junk in the fields read only on the tag byte
    task automatic push_byte(logic [7:0] b);
        push_beat(3'($urandom), 1'b0, b, $urandom);
    endtask

    // tag, length octets and the first content bytes of one object
    task automatic push_object(logic [2:0] cmd, logic [7:0] tag, logic [31:0] av,
                               logic [31:0] len, int n_oct, logic [7:0] c0,
                               logic [7:0] c1, int n_content);
        push_beat(cmd, 1'b1, tag, av);
        if (n_oct == 0)
            push_byte({1'b0, len[6:0]});
        else
        begin
            push_byte({1'b1, 7'(n_oct)});
            for (int i = n_oct - 1; i >= 0; i--)
                push_byte(8'(len >> (8 * i)));
        end
        for (int i = 0; i < n_content; i++)
            push_byte(i == 0 ? c0 : (i == 1 ? c1 : 8'($urandom)));
    endtask

    // stimulus, idling phases and end of run
    initial
    begin
        int          obj_beats;
        int          total_beats;
        int unsigned sel;
        logic [2:0]  cmd;
        logic [7:0]  tag;
        logic [31:0] len;
        logic [31:0] av;
        logic [7:0]  c0;
        int          n_oct;
        int          n_content;
        longint      total;

        // directed: short buffers, stray byte, sign zero, bad forms, overruns, wrong tag, bit strings
        push_beat(KIND_UNLISTED, 1'b1, 8'hFF, 32'd0);
        push_beat(dertlv_pkg::KIND_OID, 1'b1, dertlv_pkg::TAG_OID, 32'd1);
        push_byte(8'h00);
        push_object(dertlv_pkg::KIND_INTEGER, dertlv_pkg::TAG_INTEGER, 32'hFFFF_FFFF,
                    32'd2, 0, 8'h00, 8'h80, 2);
        push_beat(dertlv_pkg::KIND_SEQ, 1'b1, dertlv_pkg::TAG_SEQ, 32'd10);
        push_byte(8'h80);
        push_beat(dertlv_pkg::KIND_UTF8, 1'b1, dertlv_pkg::TAG_UTF8, 32'd10);
        push_byte(8'h85);
        push_object(dertlv_pkg::KIND_ANY, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4,
                    8'h00, 8'h00, 0);
        push_object(dertlv_pkg::KIND_ANY, dertlv_pkg::TAG_OCTETS, 32'd3, 32'd5, 2,
                    8'h00, 8'h00, 0);
        push_object(dertlv_pkg::KIND_OCTETS, dertlv_pkg::TAG_SEQ, 32'd2, 32'd0, 0,
                    8'h00, 8'h00, 0);
        push_object(dertlv_pkg::KIND_BITSTR, dertlv_pkg::TAG_BITSTR, 32'd2, 32'd0, 0,
                    8'h00, 8'h00, 0);
        push_object(dertlv_pkg::KIND_BITSTR, dertlv_pkg::TAG_BITSTR, 32'd3, 32'd1, 0,
                    8'h08, 8'h00, 1);

        // random: mostly well-formed objects, some noise and broken headers
        obj_beats = 0;
        while (obj_beats < N_ITEMS)
        begin
            sel = $urandom_range(99);
            if (sel < 80)
            begin
                cmd = 3'($urandom_range(7));
                if (cmd != dertlv_pkg::KIND_ANY && cmd != KIND_UNLISTED &&
                    $urandom_range(9) < 7)
                    tag = kind_tag(cmd);
                else
                    tag = 8'($urandom);
                sel = $urandom_range(9);
                if (sel < 6)
                    len = $urandom_range(4);
                else if (sel < 8)
                    len = $urandom_range(127);
                else
                    len = $urandom;
                if (len < 128 && $urandom_range(3) != 0)
                    n_oct = 0;
                else
                begin
                    n_oct = $urandom_range(1, MAX_LEN_OCTETS);
                    if (n_oct < 4)
                        len = len & ((32'd1 << (8 * n_oct)) - 1);
                end
                total = 2 + n_oct + longint'(len);
                sel = $urandom_range(9);
                if (sel < 6)
                    total = total + $urandom_range(3);
                else if (sel == 6)
                    total = total - 1;
                if (sel == 7)
                    av = $urandom;
                else if (sel == 8)
                    av = $urandom_range(1);
                else if (sel == 9 || total > 64'hFFFF_FFFF)
                    av = 32'hFFFF_FFFF;
                else
                    av = total[31:0];
                if (cmd == dertlv_pkg::KIND_INTEGER)
                    c0 = $urandom_range(1) ? 8'h00 : 8'($urandom);
                else if (cmd == dertlv_pkg::KIND_BITSTR && $urandom_range(9) < 8)
                    c0 = 8'($urandom_range(7));
                else
                    c0 = 8'($urandom);
                n_content = (len < 2 ? int'(len) : 2) + $urandom_range(2);
                // now and then cut short so the next tag byte restarts mid-way
                if ($urandom_range(19) == 0)
                    n_content = $urandom_range(n_content);
                push_object(cmd, tag, av, len, n_oct, c0, 8'($urandom), n_content);
                obj_beats += 2 + n_oct + n_content;
            end
            else if (sel < 90)
            begin
                repeat ($urandom_range(1, 3))
                    push_byte(8'($urandom));
            end
            else
            begin
                av = $urandom_range(1) ? $urandom : $urandom_range(8);
                push_beat(3'($urandom), 1'b1, 8'($urandom), av);
                n_content = $urandom_range(3);
                repeat (n_content)
                    push_byte(8'($urandom));
                obj_beats += 1 + n_content;
            end
        end
        total_beats = beat_queue.size();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // idling phases
        send_idle_pct = 35;
        recv_idle_pct = 83;
        while (beat_queue.size() > total_beats * 2 / 3)
            @(posedge clk);
        send_idle_pct = 83;
        recv_idle_pct = 35;
        while (beat_queue.size() > total_beats / 3)
            @(posedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // drain
        while (beat_queue.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("der_tlv_header_parser_tb: done, clean");
        else
            $display("der_tlv_header_parser_tb: done, errors");
        $finish;
    end

    // slave-side driver, holds a beat until it is taken
    always @(negedge clk)
    begin
        tlv_beat_t cur;
        if (rst_n && (!s_tvalid || beat_taken))
        begin
            if (beat_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cur = beat_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {cur.avail, cur.data_byte};
                s_tuser  <= {cur.first, cur.command};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // accepted slave beats feed the parser mirror
    always @(posedge clk)
    begin
        tlv_beat_t bt;
        beat_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            bt.command   = s_tuser[2:0];
            bt.first     = s_tuser[3];
            bt.data_byte = s_tdata[7:0];
            bt.avail     = s_tdata[39:8];
            parse_beat(bt);
            in_beats <= in_beats + 1;
        end
    end

    // master-side ready, with one long hold-off
    always @(negedge clk)
    begin
        logic ready_next;
        if (hold_left != 0)
        begin
            ready_next = 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && in_beats >= HOLD_AFTER)
        begin
            ready_next = 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            ready_next = ($urandom_range(99) >= recv_idle_pct);
        m_tready <= ready_next;
    end

    // result checker
    always @(posedge clk)
    begin
        tlv_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result beat: tag %0h status %0d",
                       m_tdata[7:0], m_tuser[2:0]);
                error_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (m_tuser[2:0] !== exp_r.status)
                begin
                    $error("status: expected %0d, got %0d", exp_r.status, m_tuser[2:0]);
                    error_count++;
                end
                if (m_tdata[7:0] !== exp_r.tag)
                begin
                    $error("tag: expected %0h, got %0h", exp_r.tag, m_tdata[7:0]);
                    error_count++;
                end
                if (m_tdata[10:8] !== exp_r.value_offset)
                begin
                    $error("value_offset: expected %0d, got %0d",
                           exp_r.value_offset, m_tdata[10:8]);
                    error_count++;
                end
                if (m_tdata[42:11] !== exp_r.value_length)
                begin
                    $error("value_length: expected %0d, got %0d",
                           exp_r.value_length, m_tdata[42:11]);
                    error_count++;
                end
                if (m_tdata[74:43] !== exp_r.consumed)
                begin
                    $error("consumed: expected %0d, got %0d", exp_r.consumed, m_tdata[74:43]);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("der_tlv_header_parser_tb: done, errors");
                $finish;
            end
        end
    end

endmodule
